// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_RST(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("assertion failed");

`endif

// ===== rtl/lap3d_pkg.sv =====
package lap3d_pkg;

	localparam int MaxDim = 64;
	localparam int MinDim = 3;
	localparam int DimW = $clog2(MaxDim);
	localparam int SizeW = 7;
	localparam int PosW = 6;
	localparam int CntCmpW = (SizeW > DimW + 1) ? SizeW : DimW + 1;
	localparam int StoreAw = 1 + 2 * DimW;
	localparam int WordW = 32;
	localparam int DiffW = WordW + 2;
	localparam int ProdW = WordW + DiffW;
	localparam int GainFrac = 30;
	localparam int TermW = ProdW - GainFrac;
	localparam int SumW = TermW + 3;
	localparam int QueueDepth = 4;
	localparam int QueueAw = $clog2(QueueDepth);
	localparam int CfgIdxW = 3;

	localparam logic signed [ProdW-1:0] RoundHalf = ProdW'(1) << (GainFrac - 1);
	localparam logic signed [WordW-1:0] WordMax = {1'b0, {(WordW - 1){1'b1}}};
	localparam logic signed [WordW-1:0] WordMin = {1'b1, {(WordW - 1){1'b0}}};

	typedef enum logic [CfgIdxW-1:0] {
		REG_SIZE_X,
		REG_SIZE_Y,
		REG_SIZE_Z,
		REG_GAIN_X,
		REG_GAIN_Y,
		REG_GAIN_Z,
		REG_SOURCE
	} cfg_reg_t;

	typedef struct packed {
		logic [SizeW-1:0] size_x;
		logic [SizeW-1:0] size_y;
		logic [SizeW-1:0] size_z;
	} dims_t;

	typedef struct packed {
		logic signed [WordW-1:0] gain_x;
		logic signed [WordW-1:0] gain_y;
		logic signed [WordW-1:0] gain_z;
		logic signed [WordW-1:0] source_offset;
	} gains_t;

	typedef struct packed {
		logic [PosW-1:0] pos_outer;
		logic [PosW-1:0] pos_middle;
		logic [PosW-1:0] pos_inner;
		logic            grid_done;
	} tag_t;

	typedef struct packed {
		logic signed [WordW-1:0] center;
		logic signed [DiffW-1:0] diff_x;
		logic signed [DiffW-1:0] diff_y;
		logic signed [DiffW-1:0] diff_z;
		tag_t                    tag;
	} item_t;

	// sizes below the minimum act as the minimum, above the maximum as the maximum
	function automatic logic [CntCmpW-1:0] eff_size(input logic [SizeW-1:0] s);
		logic [CntCmpW-1:0] w;
		w = CntCmpW'(s);
		if (w < CntCmpW'(MinDim)) begin
			return CntCmpW'(MinDim);
		end
		if (w > CntCmpW'(MaxDim)) begin
			return CntCmpW'(MaxDim);
		end
		return w;
	endfunction

endpackage

// ===== rtl/lap3d_if.sv =====
interface lap3d_in_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [lap3d_pkg::WordW-1:0]     old_potential;

	modport source(output valid, output old_potential, input ready);
	modport sink(input valid, input old_potential, output ready);
endinterface

interface lap3d_out_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [lap3d_pkg::WordW-1:0]     new_potential;
	logic [lap3d_pkg::PosW-1:0]             pos_outer;
	logic [lap3d_pkg::PosW-1:0]             pos_middle;
	logic [lap3d_pkg::PosW-1:0]             pos_inner;
	logic                                   grid_done;

	modport source(output valid, output new_potential, output pos_outer, output pos_middle,
		output pos_inner, output grid_done, input ready);
	modport sink(input valid, input new_potential, input pos_outer, input pos_middle,
		input pos_inner, input grid_done, output ready);
endinterface

interface lap3d_cfg_if;
	logic                                   valid;
	logic                                   ready;
	logic [lap3d_pkg::CfgIdxW-1:0]          index;
	logic [lap3d_pkg::WordW-1:0]            data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ===== rtl/lap3d_ram.sv =====
module lap3d_ram #(
	parameter int AddrW = 13,
	parameter int DataW = 32
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [DataW-1:0] wdata,
	input  logic             re,
	input  logic [AddrW-1:0] raddr_a,
	input  logic [AddrW-1:0] raddr_b,
	output logic [DataW-1:0] rdata_a,
	output logic [DataW-1:0] rdata_b
);

	logic [DataW-1:0] mem [2**AddrW];

	// read returns the old word when the same address is written in that cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// ===== rtl/lap3d_front.sv =====
module lap3d_front (
	input  logic               clk,
	input  logic               arst_n,
	lap3d_in_if.sink           samples,
	input  lap3d_pkg::dims_t   dims,
	output lap3d_pkg::item_t   item,
	output logic               item_valid,
	input  logic               item_ready
);

	localparam int DimW = lap3d_pkg::DimW;
	localparam int CW = lap3d_pkg::CntCmpW;
	localparam int AW = lap3d_pkg::StoreAw;
	localparam int WordW = lap3d_pkg::WordW;
	localparam int DiffW = lap3d_pkg::DiffW;
	localparam int PosW = lap3d_pkg::PosW;

	logic [DimW-1:0] outer_q, middle_q, inner_q;
	logic            slot_q;
	logic [CW-1:0]   sx, sy, sz;
	logic [CW-1:0]   outer_w, middle_w, inner_w;
	logic            interior, last_point, accept;
	logic [AW-1:0]   addr_cur, addr_c, addr_jp, addr_jm, addr_kp, addr_km;

	logic signed [WordW-1:0] c_rd, xm_rd, yp_rd, ym_rd, zp_rd, zm_rd;

	logic                    valid_s1;
	logic signed [WordW-1:0] sample_s1;
	lap3d_pkg::tag_t         tag_s1;

	assign sx = lap3d_pkg::eff_size(dims.size_x);
	assign sy = lap3d_pkg::eff_size(dims.size_y);
	assign sz = lap3d_pkg::eff_size(dims.size_z);

	assign outer_w = CW'(outer_q);
	assign middle_w = CW'(middle_q);
	assign inner_w = CW'(inner_q);

	// the sample at plane i completes the stencil of the point one plane back
	assign interior = (outer_w >= CW'(2)) && (outer_w <= sx - CW'(1))
		&& (middle_w >= CW'(1)) && (middle_w <= sy - CW'(2))
		&& (inner_w >= CW'(1)) && (inner_w <= sz - CW'(2));
	assign last_point = (outer_w == sx - CW'(1)) && (middle_w == sy - CW'(2))
		&& (inner_w == sz - CW'(2));

	assign samples.ready = !valid_s1 || item_ready;
	assign accept = samples.valid && samples.ready;

	assign addr_cur = {slot_q, middle_q, inner_q};
	assign addr_c = {~slot_q, middle_q, inner_q};
	assign addr_jp = {~slot_q, middle_q + DimW'(1), inner_q};
	assign addr_jm = {~slot_q, middle_q - DimW'(1), inner_q};
	assign addr_kp = {~slot_q, middle_q, inner_q + DimW'(1)};
	assign addr_km = {~slot_q, middle_q, inner_q - DimW'(1)};

	// three copies of the plane store, each written alike, two words read from each
	lap3d_ram #(.AddrW(AW), .DataW(WordW)) u_ram_x (
		.clk(clk), .we(accept), .waddr(addr_cur), .wdata(samples.old_potential),
		.re(accept), .raddr_a(addr_c), .raddr_b(addr_cur), .rdata_a(c_rd), .rdata_b(xm_rd)
	);

	lap3d_ram #(.AddrW(AW), .DataW(WordW)) u_ram_y (
		.clk(clk), .we(accept), .waddr(addr_cur), .wdata(samples.old_potential),
		.re(accept), .raddr_a(addr_jp), .raddr_b(addr_jm), .rdata_a(yp_rd), .rdata_b(ym_rd)
	);

	lap3d_ram #(.AddrW(AW), .DataW(WordW)) u_ram_z (
		.clk(clk), .we(accept), .waddr(addr_cur), .wdata(samples.old_potential),
		.re(accept), .raddr_a(addr_kp), .raddr_b(addr_km), .rdata_a(zp_rd), .rdata_b(zm_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outer_q <= '0;
			middle_q <= '0;
			inner_q <= '0;
			slot_q <= 1'b0;
		end else if (accept) begin
			if (inner_w + CW'(1) >= sz) begin
				inner_q <= '0;
				if (middle_w + CW'(1) >= sy) begin
					middle_q <= '0;
					slot_q <= ~slot_q;
					outer_q <= (outer_w + CW'(1) >= sx) ? '0 : outer_q + DimW'(1);
				end else begin
					middle_q <= middle_q + DimW'(1);
				end
			end else begin
				inner_q <= inner_q + DimW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= interior;
		end else if (item_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= samples.old_potential;
			tag_s1.pos_outer <= PosW'(outer_q - DimW'(1));
			tag_s1.pos_middle <= PosW'(middle_q);
			tag_s1.pos_inner <= PosW'(inner_q);
			tag_s1.grid_done <= last_point;
		end
	end

	assign item_valid = valid_s1;

	always_comb begin
		item.center = c_rd;
		item.diff_x = DiffW'(sample_s1) + DiffW'(xm_rd) - (DiffW'(c_rd) <<< 1);
		item.diff_y = DiffW'(yp_rd) + DiffW'(ym_rd) - (DiffW'(c_rd) <<< 1);
		item.diff_z = DiffW'(zp_rd) + DiffW'(zm_rd) - (DiffW'(c_rd) <<< 1);
		item.tag = tag_s1;
	end

endmodule

// ===== rtl/lap3d_queue.sv =====
module lap3d_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  lap3d_pkg::item_t push_item,
	output logic             pop_valid,
	input  logic             pop_ready,
	output lap3d_pkg::item_t pop_item
);

	localparam int Depth = lap3d_pkg::QueueDepth;
	localparam int AW = lap3d_pkg::QueueAw;

	lap3d_pkg::item_t entry_q [Depth];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [AW:0]      count_q;
	logic             do_push, do_pop;

	assign push_ready = (count_q != (AW + 1)'(Depth));
	assign pop_valid = (count_q != '0);
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;
	assign pop_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (AW + 1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (AW + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== rtl/lap3d_back.sv =====
module lap3d_back (
	input  logic               clk,
	input  logic               arst_n,
	input  lap3d_pkg::gains_t  gains,
	input  lap3d_pkg::item_t   item,
	input  logic               item_valid,
	output logic               item_ready,
	lap3d_out_if.source        results
);

	localparam int WordW = lap3d_pkg::WordW;
	localparam int ProdW = lap3d_pkg::ProdW;
	localparam int TermW = lap3d_pkg::TermW;
	localparam int SumW = lap3d_pkg::SumW;
	localparam int GainFrac = lap3d_pkg::GainFrac;

	logic ready_s2, ready_s3, ready_s4;

	// multiply stage
	logic                    valid_s2;
	logic signed [ProdW-1:0] prod_x_s2, prod_y_s2, prod_z_s2;
	logic signed [WordW-1:0] center_s2;
	lap3d_pkg::tag_t         tag_s2;

	// rounding stage
	logic                    valid_s3;
	logic signed [TermW-1:0] term_x_s3, term_y_s3, term_z_s3;
	logic signed [WordW-1:0] center_s3;
	lap3d_pkg::tag_t         tag_s3;

	// sum, saturate, output register
	logic                    valid_s4;
	logic signed [WordW-1:0] result_s4;
	lap3d_pkg::tag_t         tag_s4;

	logic signed [SumW-1:0]  total;
	logic signed [WordW-1:0] sat;

	assign ready_s4 = !valid_s4 || results.ready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign item_ready = ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s2) begin
				valid_s2 <= item_valid;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && item_valid) begin
			prod_x_s2 <= ProdW'(gains.gain_x) * ProdW'(item.diff_x);
			prod_y_s2 <= ProdW'(gains.gain_y) * ProdW'(item.diff_y);
			prod_z_s2 <= ProdW'(gains.gain_z) * ProdW'(item.diff_z);
			center_s2 <= item.center;
			tag_s2 <= item.tag;
		end
	end

	// round half up: add half an lsb, then floor shift
	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			term_x_s3 <= TermW'((prod_x_s2 + lap3d_pkg::RoundHalf) >>> GainFrac);
			term_y_s3 <= TermW'((prod_y_s2 + lap3d_pkg::RoundHalf) >>> GainFrac);
			term_z_s3 <= TermW'((prod_z_s2 + lap3d_pkg::RoundHalf) >>> GainFrac);
			center_s3 <= center_s2;
			tag_s3 <= tag_s2;
		end
	end

	always_comb begin
		total = SumW'(center_s3) + SumW'(term_x_s3) + SumW'(term_y_s3) + SumW'(term_z_s3)
			+ SumW'(gains.source_offset);
		if (total > SumW'(lap3d_pkg::WordMax)) begin
			sat = lap3d_pkg::WordMax;
		end else if (total < SumW'(lap3d_pkg::WordMin)) begin
			sat = lap3d_pkg::WordMin;
		end else begin
			sat = WordW'(total);
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s4 && valid_s3) begin
			result_s4 <= sat;
			tag_s4 <= tag_s3;
		end
	end

	assign results.valid = valid_s4;
	assign results.new_potential = result_s4;
	assign results.pos_outer = tag_s4.pos_outer;
	assign results.pos_middle = tag_s4.pos_middle;
	assign results.pos_inner = tag_s4.pos_inner;
	assign results.grid_done = tag_s4.grid_done;

endmodule

// ===== rtl/laplacian_3d_stencil_step_core.sv =====
// registers in order: front, queue, multiply, rounding, output; one sample per cycle
// while not back-pressured; the plane store is three copies with one write and two read
// ports each, so the center and five neighbor words are read when a sample is taken
// reset: arst_n low clears the raster counters, plane slot, stage valids, queue pointers and
// config registers (sizes 64, gains and source 0); the plane store is not cleared
module laplacian_3d_stencil_step_core (
	input  logic        clk,
	input  logic        arst_n,
	lap3d_cfg_if.sink   cfg,
	lap3d_in_if.sink    samples,
	lap3d_out_if.source results
);

	localparam int SizeW = lap3d_pkg::SizeW;

	lap3d_pkg::dims_t  dims_q;
	lap3d_pkg::gains_t gains_q;

	lap3d_pkg::item_t  front_item, back_item;
	logic              front_valid, front_ready, back_valid, back_ready;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q.size_x <= SizeW'(lap3d_pkg::MaxDim);
			dims_q.size_y <= SizeW'(lap3d_pkg::MaxDim);
			dims_q.size_z <= SizeW'(lap3d_pkg::MaxDim);
			gains_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (lap3d_pkg::cfg_reg_t'(cfg.index))
				lap3d_pkg::REG_SIZE_X: dims_q.size_x <= cfg.data[SizeW-1:0];
				lap3d_pkg::REG_SIZE_Y: dims_q.size_y <= cfg.data[SizeW-1:0];
				lap3d_pkg::REG_SIZE_Z: dims_q.size_z <= cfg.data[SizeW-1:0];
				lap3d_pkg::REG_GAIN_X: gains_q.gain_x <= cfg.data;
				lap3d_pkg::REG_GAIN_Y: gains_q.gain_y <= cfg.data;
				lap3d_pkg::REG_GAIN_Z: gains_q.gain_z <= cfg.data;
				lap3d_pkg::REG_SOURCE: gains_q.source_offset <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	lap3d_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples),
		.dims(dims_q),
		.item(front_item),
		.item_valid(front_valid),
		.item_ready(front_ready)
	);

	lap3d_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(front_valid),
		.push_ready(front_ready),
		.push_item(front_item),
		.pop_valid(back_valid),
		.pop_ready(back_ready),
		.pop_item(back_item)
	);

	lap3d_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.gains(gains_q),
		.item(back_item),
		.item_valid(back_valid),
		.item_ready(back_ready),
		.results(results)
	);

endmodule

// ===== rtl/lap3d_checker.sv =====
`include "assert_macros.svh"

module lap3d_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              results_valid,
	input logic                              results_ready,
	input logic [lap3d_pkg::WordW-1:0]       new_potential,
	input logic [lap3d_pkg::PosW-1:0]        pos_outer,
	input logic [lap3d_pkg::PosW-1:0]        pos_middle,
	input logic [lap3d_pkg::PosW-1:0]        pos_inner,
	input logic                              grid_done
);

	logic                                            stall;
	logic [lap3d_pkg::WordW+3*lap3d_pkg::PosW:0]     out_beat;

	assign stall = results_valid && !results_ready;
	assign out_beat = {new_potential, pos_outer, pos_middle, pos_inner, grid_done};

	// a stalled result keeps its beat
	`ASSERT_RST(a_result_held, clk, arst_n, stall |=> results_valid && $stable(out_beat))

	// reset empties the output register by the next edge
	`ASSERT_ALWAYS(a_quiet_in_reset, clk, !arst_n |=> !results_valid)

	// interior points never sit on a low face
	`ASSERT_RST(a_interior_pos, clk, arst_n, results_valid |-> pos_outer != '0 && pos_middle != '0 && pos_inner != '0)

endmodule

bind laplacian_3d_stencil_step_core lap3d_checker u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.results_valid(results.valid),
	.results_ready(results.ready),
	.new_potential(results.new_potential),
	.pos_outer(results.pos_outer),
	.pos_middle(results.pos_middle),
	.pos_inner(results.pos_inner),
	.grid_done(results.grid_done)
);

// ===== dv/tb_laplacian_3d_stencil_step_core.sv =====
module tb_laplacian_3d_stencil_step_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MaxDim = lap3d_pkg::MaxDim;
	localparam int MinDim = lap3d_pkg::MinDim;
	localparam int CfgIdxW = lap3d_pkg::CfgIdxW;
	localparam int WordW = lap3d_pkg::WordW;
	localparam int SizeW = lap3d_pkg::SizeW;
	localparam int PosW = lap3d_pkg::PosW;
	localparam int GainFrac = lap3d_pkg::GainFrac;
	localparam logic signed [WordW-1:0] WordMax = lap3d_pkg::WordMax;
	localparam logic signed [WordW-1:0] WordMin = lap3d_pkg::WordMin;

	localparam int unsigned HoldCycles = 300;
	localparam int unsigned SettleCycles = 12;
	localparam int unsigned QuietLimit = 4000;
	localparam int unsigned PlaneWords = MaxDim * MaxDim;
	localparam logic [CfgIdxW-1:0] RegSpare = 3'd7;

	typedef struct packed {
		logic signed [WordW-1:0] value;
		lap3d_pkg::tag_t         tag;
	} stencil_pt_t;

	class laplace_checker;
		logic [SizeW-1:0]        size_x, size_y, size_z;
		logic signed [WordW-1:0] gain_x, gain_y, gain_z, source_offset;
		logic signed [WordW-1:0] plane_mem [2 * PlaneWords];
		int unsigned             cnt_outer, cnt_middle, cnt_inner;
		bit                      slot;
		stencil_pt_t             due_updates[$];
		int unsigned             errors;
		int unsigned             updates_checked;

		function new();
			size_x = 7'd64;
			size_y = 7'd64;
			size_z = 7'd64;
			gain_x = '0;
			gain_y = '0;
			gain_z = '0;
			source_offset = '0;
			cnt_outer = 0;
			cnt_middle = 0;
			cnt_inner = 0;
			slot = 1'b0;
			errors = 0;
			updates_checked = 0;
		endfunction

		function void load_reg(logic [CfgIdxW-1:0] idx, logic [WordW-1:0] val);
			case (idx)
				lap3d_pkg::REG_SIZE_X: size_x = val[SizeW-1:0];
				lap3d_pkg::REG_SIZE_Y: size_y = val[SizeW-1:0];
				lap3d_pkg::REG_SIZE_Z: size_z = val[SizeW-1:0];
				lap3d_pkg::REG_GAIN_X: gain_x = val;
				lap3d_pkg::REG_GAIN_Y: gain_y = val;
				lap3d_pkg::REG_GAIN_Z: gain_z = val;
				lap3d_pkg::REG_SOURCE: source_offset = val;
				default: ;
			endcase
		endfunction

		function int unsigned extent(logic [SizeW-1:0] s);
			if (s < MinDim) begin
				return MinDim;
			end
			return (s > MaxDim) ? MaxDim : s;
		endfunction

		function int unsigned slot_addr(bit sl, int unsigned j, int unsigned k);
			return (sl * PlaneWords + j * MaxDim + k) % (2 * PlaneWords);
		endfunction

		function logic signed [WordW-1:0] fetch(bit sl, int unsigned j, int unsigned k);
			return plane_mem[slot_addr(sl, j, k)];
		endfunction

		// gain times difference, back to Q16.16 with ties rounded up
		function logic signed [71:0] axis_term(logic signed [WordW-1:0] g,
				logic signed [35:0] d);
			logic signed [71:0] prod;
			prod = g * d;
			return (prod + (72'sd1 <<< (GainFrac - 1))) >>> GainFrac;
		endfunction

		function bit at_grid_start();
			return cnt_outer == 0 && cnt_middle == 0 && cnt_inner == 0;
		endfunction

		function void take_sample(logic signed [WordW-1:0] v);
			int unsigned        sx, sy, sz, i, j, k;
			bit                 cur, prv;
			logic signed [WordW-1:0] c;
			logic signed [35:0] dx, dy, dz;
			logic signed [71:0] acc;
			stencil_pt_t        upd;
			sx = extent(size_x);
			sy = extent(size_y);
			sz = extent(size_z);
			i = cnt_outer;
			j = cnt_middle;
			k = cnt_inner;
			cur = slot;
			prv = ~slot;
			if (i >= 2 && i <= sx - 1 && j >= 1 && j <= sy - 2 && k >= 1 && k <= sz - 2) begin
				c = fetch(prv, j, k);
				dx = v + fetch(cur, j, k) - 2 * c;
				dy = fetch(prv, j + 1, k) + fetch(prv, j - 1, k) - 2 * c;
				dz = fetch(prv, j, k + 1) + fetch(prv, j, k - 1) - 2 * c;
				acc = c + axis_term(gain_x, dx) + axis_term(gain_y, dy)
					+ axis_term(gain_z, dz) + source_offset;
				if (acc > WordMax) begin
					upd.value = WordMax;
				end else if (acc < WordMin) begin
					upd.value = WordMin;
				end else begin
					upd.value = acc[WordW-1:0];
				end
				upd.tag.pos_outer = PosW'(i - 1);
				upd.tag.pos_middle = PosW'(j);
				upd.tag.pos_inner = PosW'(k);
				upd.tag.grid_done = (i - 1 == sx - 2) && (j == sy - 2) && (k == sz - 2);
				due_updates.push_back(upd);
			end
			plane_mem[slot_addr(cur, j, k)] = v;
			// counters left past a shrunk extent wrap on this step
			if (k + 1 >= sz) begin
				cnt_inner = 0;
				if (j + 1 >= sy) begin
					cnt_middle = 0;
					slot = prv;
					cnt_outer = (i + 1 >= sx) ? 0 : i + 1;
				end else begin
					cnt_middle = j + 1;
				end
			end else begin
				cnt_inner = k + 1;
			end
		endfunction

		function void compare_field(string name, logic signed [63:0] want,
				logic signed [63:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_update(stencil_pt_t got);
			stencil_pt_t want;
			if (due_updates.size() == 0) begin
				$error("unexpected update: new_potential %0d at %0d/%0d/%0d", got.value,
					got.tag.pos_outer, got.tag.pos_middle, got.tag.pos_inner);
				errors++;
				return;
			end
			want = due_updates.pop_front();
			updates_checked++;
			compare_field("new_potential", want.value, got.value);
			compare_field("pos_outer", want.tag.pos_outer, got.tag.pos_outer);
			compare_field("pos_middle", want.tag.pos_middle, got.tag.pos_middle);
			compare_field("pos_inner", want.tag.pos_inner, got.tag.pos_inner);
			compare_field("grid_done", want.tag.grid_done, got.tag.grid_done);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	lap3d_cfg_if cfg_bus();
	lap3d_in_if  in_bus();
	lap3d_out_if out_bus();

	laplacian_3d_stencil_step_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_bus),
		.samples (in_bus),
		.results (out_bus)
	);

	laplace_checker chk;
	int unsigned    send_gap_pct;
	int unsigned    sink_gap_pct;
	bit             hold_req;
	int unsigned    samples_sent;
	int unsigned    grids_run;
	int unsigned    quiet_cycles;

	always #10 clk = ~clk;

	// handshake monitor and watchdog
	always @(posedge clk) begin : monitor
		stencil_pt_t seen;
		bit          moved;
		moved = 1'b0;
		if (arst_n) begin
			if (cfg_bus.valid && cfg_bus.ready) begin
				chk.load_reg(cfg_bus.index, cfg_bus.data);
				moved = 1'b1;
			end
			if (in_bus.valid && in_bus.ready) begin
				chk.take_sample(in_bus.old_potential);
				moved = 1'b1;
			end
			if (out_bus.valid && out_bus.ready) begin
				seen.value = out_bus.new_potential;
				seen.tag.pos_outer = out_bus.pos_outer;
				seen.tag.pos_middle = out_bus.pos_middle;
				seen.tag.pos_inner = out_bus.pos_inner;
				seen.tag.grid_done = out_bus.grid_done;
				chk.check_update(seen);
				moved = 1'b1;
			end
		end
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= QuietLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// output side: random backpressure plus an occasional long hold-off
	initial begin : sink_side
		int unsigned hold_left;
		hold_left = 0;
		out_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HoldCycles;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				out_bus.ready <= 1'b0;
				hold_left--;
			end else begin
				out_bus.ready <= ($urandom_range(99) >= sink_gap_pct);
			end
		end
	end

	function automatic logic [WordW-1:0] rand_sample(input bit wild);
		if (!wild) begin
			return $urandom_range(0, 32'h0003FFFF) - 32'h00020000;
		end
		case ($urandom_range(5))
			0: return WordMax;
			1: return WordMin;
			2: return 32'hFFFFFFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [WordW-1:0] rand_gain();
		case ($urandom_range(7))
			0: return WordMax;
			1: return WordMin;
			2: return $urandom_range(1) ? 32'h20000000 : 32'hE0000000;
			3: return $urandom;
			default: return $urandom_range(0, 32'h0FFFFFFF) - 32'h08000000;
		endcase
	endfunction

	function automatic logic [WordW-1:0] rand_source();
		case ($urandom_range(5))
			0: return WordMax;
			1: return WordMin;
			2: return '0;
			3: return $urandom;
			default: return $urandom_range(0, 32'h0007FFFF) - 32'h00040000;
		endcase
	endfunction

	function automatic logic [SizeW-1:0] rand_extent(input int unsigned hi);
		if ($urandom_range(7) == 0) begin
			return SizeW'($urandom_range(0, 2));
		end
		return SizeW'($urandom_range(3, hi));
	endfunction

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [WordW-1:0] val);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= val;
		do @(posedge clk); while (!cfg_bus.ready);
		@(negedge clk);
	endtask

	task automatic apply_settings(input logic [SizeW-1:0] sx, input logic [SizeW-1:0] sy,
			input logic [SizeW-1:0] sz, input logic [WordW-1:0] gx,
			input logic [WordW-1:0] gy, input logic [WordW-1:0] gz,
			input logic [WordW-1:0] src, input bit poke_spare);
		if (poke_spare) begin
			write_reg(RegSpare, 32'hFFFFFFFF);
		end
		write_reg(lap3d_pkg::REG_SIZE_X, WordW'(sx));
		write_reg(lap3d_pkg::REG_SIZE_Y, WordW'(sy));
		write_reg(lap3d_pkg::REG_SIZE_Z, WordW'(sz));
		write_reg(lap3d_pkg::REG_GAIN_X, gx);
		write_reg(lap3d_pkg::REG_GAIN_Y, gy);
		write_reg(lap3d_pkg::REG_GAIN_Z, gz);
		write_reg(lap3d_pkg::REG_SOURCE, src);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic push_sample(input logic [WordW-1:0] v);
		if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
			in_bus.valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_gap_pct);
		end
		in_bus.valid <= 1'b1;
		in_bus.old_potential <= v;
		do @(posedge clk); while (!in_bus.ready);
		@(negedge clk);
		samples_sent++;
	endtask

	// sends samples until the raster position is back at the grid origin
	task automatic send_grid(input bit wild);
		do push_sample(rand_sample(wild)); while (!chk.at_grid_start());
		grids_run++;
	endtask

	task automatic settle();
		in_bus.valid <= 1'b0;
		while (chk.due_updates.size() != 0) @(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic random_grids(input int unsigned budget);
		int unsigned start;
		bit          wild;
		start = samples_sent;
		while (samples_sent - start < budget) begin
			wild = ($urandom_range(3) == 0);
			apply_settings(rand_extent(4), rand_extent(4), rand_extent(6), rand_gain(),
				rand_gain(), rand_gain(), rand_source(), 1'b0);
			repeat ($urandom_range(1, 2)) send_grid(wild);
			settle();
		end
	endtask

	task automatic hold_off_grid();
		int unsigned saved;
		saved = send_gap_pct;
		send_gap_pct = 0;
		apply_settings(7'd5, 7'd5, 7'd5, rand_gain(), rand_gain(), rand_gain(), rand_source(),
			1'b0);
		hold_req = 1'b1;
		send_grid(1'b0);
		settle();
		send_gap_pct = saved;
	endtask

	// extents shrink after two full planes of a grid, so every neighbor read is already stored
	task automatic shrink_inside_grid();
		int unsigned extra;
		extra = $urandom_range(0, 24);
		apply_settings(7'd5, 7'd5, 7'd5, rand_gain(), rand_gain(), rand_gain(), rand_source(),
			1'b0);
		repeat (50 + extra) push_sample(rand_sample(1'b0));
		settle();
		apply_settings(SizeW'($urandom_range(3, 5)), SizeW'($urandom_range(3, 5)),
			SizeW'($urandom_range(3, 5)), rand_gain(), rand_gain(), rand_gain(),
			rand_source(), 1'b0);
		send_grid(1'b0);
		settle();
	endtask

	initial begin : stimulus
		int unsigned        n;
		logic [WordW-1:0]   v;
		arst_n = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;
		in_bus.valid = 1'b0;
		in_bus.old_potential = '0;
		send_gap_pct = 23;
		sink_gap_pct = 87;
		samples_sent = 0;
		grids_run = 0;
		quiet_cycles = 0;
		chk = new();
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// smallest grid from sub-minimum size codes, extreme gains and samples
		apply_settings(7'd0, 7'd1, 7'd2, WordMax, WordMin, 32'h40000000, WordMin, 1'b1);
		for (n = 0; n < 27; n++) begin
			case (n % 4)
				0: v = WordMax;
				1: v = WordMin;
				2: v = '0;
				default: v = 32'hFFFFFFFF;
			endcase
			push_sample(v);
		end
		settle();
		grids_run++;

		random_grids(30);
		hold_off_grid();

		send_gap_pct = 87;
		sink_gap_pct = 23;
		random_grids(30);
		shrink_inside_grid();

		send_gap_pct = 0;
		sink_gap_pct = 0;
		random_grids(30);

		$display("covered %0d samples over %0d grids, %0d updates checked", samples_sent,
			grids_run, chk.updates_checked);
		$display("small extents with clamped low size codes, mid-grid shrink, long output hold-off");
		if (chk.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
